// ===== sv/bernoulli_naive_bayes_scorer_unit_assert.svh =====
// Assertion macros shared by the scorer modules.
`ifndef BERNOULLI_NAIVE_BAYES_SCORER_UNIT_ASSERT_SVH
`define BERNOULLI_NAIVE_BAYES_SCORER_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define BNB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define BNB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== sv/bnb_pkg.sv =====
// ----------------------------------------------------------------------------
// bnb_pkg
// Shared constants and types of the Bernoulli naive Bayes scorer.
// ----------------------------------------------------------------------------
package bnb_pkg;
	localparam int MaxClasses = 4;
	localparam int MaxEntries = 1024;
	localparam int FeatureBits = 20;
	localparam int LogBits = 27;
	localparam int ScoreBits = 37;
	localparam int AccBits = 38;
	localparam int ClassBits = 2;
	localparam int SlotBits = 10;
	localparam int PosBits = 11;
	localparam int CcBits = 3;
	localparam int TdataBits = 88;
	localparam int OutBits = 40;
	localparam logic [0:0] OpLoad = 1'b0;
	localparam logic [0:0] OpSample = 1'b1;
	localparam logic [0:0] RegClassCount = 1'b0;
	localparam logic [0:0] RegEntries = 1'b1;

	typedef struct packed {
		logic [FeatureBits-1:0] feature;
		logic signed [LogBits-1:0] log_present;
		logic signed [LogBits-1:0] log_absent;
	} entry_t;

	// Clamp a loaded log value to at most zero.
	function automatic logic signed [LogBits-1:0] clamp_log(input logic signed [LogBits-1:0] v);
		clamp_log = v[LogBits-1] ? v : '0;
	endfunction
endpackage

// ===== sv/bnb_bank.sv =====
// ----------------------------------------------------------------------------
// bnb_bank
// Model table of one class: synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module bnb_bank import bnb_pkg::*; (
	input  logic                clk,
	input  logic                we,
	input  logic [SlotBits-1:0] waddr,
	input  entry_t              wdata,
	input  logic [SlotBits-1:0] raddr,
	output entry_t              rdata
);
	entry_t mem [MaxEntries];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/bnb_lane.sv =====
// ----------------------------------------------------------------------------
// bnb_lane
// One class: walks its entry list against the current sample id, summing the
// log terms with a floor at -2^36.
// ----------------------------------------------------------------------------
module bnb_lane import bnb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   clear,
	input  logic                   enable,
	input  logic [FeatureBits-1:0] fid,
	input  logic [PosBits-1:0]     limit,
	input  logic                   we,
	input  logic [SlotBits-1:0]    waddr,
	input  entry_t                 wdata,
	output logic                   done,
	output logic signed [ScoreBits-1:0] score
);
	localparam logic signed [AccBits-1:0] Floor = -(AccBits'(1) <<< 36);

	logic [PosBits-1:0] pos_q;
	logic signed [ScoreBits-1:0] score_q;
	logic busy_q, rd_q;
	entry_t ent;
	logic [SlotBits-1:0] raddr;
	logic at_end;
	logic [PosBits-1:0] pos_n;
	logic signed [AccBits-1:0] sum;
	logic signed [LogBits-1:0] delta;
	logic take, stop;

	assign pos_n = (rd_q && take) ? pos_q + 1'b1 : pos_q;
	assign raddr = pos_n[SlotBits-1:0];

	bnb_bank u_bank (.clk, .we, .waddr, .wdata, .raddr, .rdata(ent));

	assign at_end = (pos_q >= limit);
	assign take = (ent.feature <= fid) && !at_end;
	assign stop = at_end || (ent.feature >= fid);
	assign delta = (ent.feature < fid) ? ent.log_absent : ent.log_present;
	assign sum = AccBits'(score_q) + AccBits'(delta);

	// rd_q: entry at pos_q valid on ent this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			score_q <= '0;
			busy_q <= 1'b0;
			rd_q <= 1'b0;
		end else if (clear) begin
			pos_q <= '0;
			score_q <= '0;
			busy_q <= 1'b0;
			rd_q <= 1'b0;
		end else if (start && enable) begin
			busy_q <= 1'b1;
			rd_q <= 1'b0;
		end else if (busy_q) begin
			if (!rd_q) begin
				rd_q <= 1'b1;
			end else begin
				if (take) begin
					pos_q <= pos_q + 1'b1;
					score_q <= (sum < Floor) ? ScoreBits'(Floor) : sum[ScoreBits-1:0];
				end
				if (stop || (take && pos_q + 1'b1 >= limit)) begin
					busy_q <= 1'b0;
					rd_q <= 1'b0;
				end
			end
		end
	end

	assign done = !busy_q;
	assign score = score_q;

	`include "bernoulli_naive_bayes_scorer_unit_assert.svh"
	`BNB_ASSERT_IMP(a_floor, 1'b1, score_q >= ScoreBits'(Floor))
	`BNB_ASSERT_IMP(a_sign, 1'b1, score_q <= 0)
	`BNB_ASSERT_NXT(a_clr, clear, pos_q == '0)
endmodule

// ===== sv/bernoulli_naive_bayes_scorer_unit.sv =====
// ----------------------------------------------------------------------------
// bernoulli_naive_bayes_scorer_unit
// Bernoulli naive Bayes scorer with one RAM bank per class.
// ----------------------------------------------------------------------------
// One item at a time. A sample item walks the model entries of every class
// in use until an entry stops the walk, counting the entry that stops it
// (one RAM read per entry per cycle, all classes in parallel). An item
// marked last then runs the argmax over the classes in use and presents
// the result, held while m_tready stays low. No clearing pass after reset.
module bernoulli_naive_bayes_scorer_unit import bnb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// tdata: class_index, slot, feature_id, log_present, log_absent, zero pad
	input  logic [TdataBits-1:0] s_tdata,
	input  logic                 s_tuser,   // operation
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// tdata: predicted_class, best_score, zero pad
	output logic [OutBits-1:0]   m_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [0:0]           cfg_index,
	input  logic [10:0]          cfg_data
);
	typedef enum logic [3:0] {
		StIdle = 4'b0001, StRun = 4'b0010, StPick = 4'b0100, StOut = 4'b1000
	} state_t;

	state_t state_q;
	logic [CcBits-1:0] cc_q;
	logic [PosBits-1:0] ne_q;
	logic [FeatureBits-1:0] fid_q;
	logic last_q, go_s1;
	logic [ClassBits-1:0] idx_q, best_q;
	logic signed [ScoreBits-1:0] best_val_q;
	logic [ClassBits:0] nc;
	logic [MaxClasses-1:0] done;
	logic signed [ScoreBits-1:0] score [MaxClasses];
	logic accept, is_load, clear;
	logic [ClassBits-1:0] cls;
	logic [SlotBits-1:0] slot;
	logic [PosBits-1:0] limit;
	entry_t wentry;

	assign cls = s_tdata[1:0];
	assign slot = s_tdata[11:2];
	assign wentry.feature = s_tdata[31:12];
	assign wentry.log_present = clamp_log(s_tdata[58:32]);
	assign wentry.log_absent = clamp_log(s_tdata[85:59]);

	assign nc = (cc_q == '0) ? 3'd1 : (cc_q > 3'(MaxClasses)) ? 3'(MaxClasses) : cc_q;
	assign limit = (ne_q > 11'(MaxEntries)) ? 11'(MaxEntries) : ne_q;
	assign s_tready = (state_q == StIdle);
	assign cfg_ready = 1'b1;
	assign accept = s_tvalid && s_tready;
	assign is_load = (s_tuser == OpLoad);
	assign clear = (state_q == StOut) && m_tready;

	genvar g;
	generate
		for (g = 0; g < MaxClasses; g++) begin : g_lane
			bnb_lane u_lane (
				.clk, .arst_n,
				.start(accept && !is_load), .clear,
				.enable(3'(g) < nc),
				.fid(fid_q), .limit,
				.we(accept && is_load && cls == ClassBits'(g)),
				.waddr(slot), .wdata(wentry),
				.done(done[g]), .score(score[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			cc_q <= 3'd2;
			ne_q <= 11'd1024;
			last_q <= 1'b0;
			go_s1 <= 1'b0;
			idx_q <= '0;
			best_q <= '0;
			best_val_q <= '0;
			fid_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == RegClassCount) cc_q <= cfg_data[CcBits-1:0];
				else cc_q <= cc_q;
				if (cfg_index == RegEntries) ne_q <= cfg_data;
			end
			go_s1 <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (accept && !is_load) begin
						state_q <= StRun;
						last_q <= s_tlast;
						go_s1 <= 1'b1;
						fid_q <= s_tdata[31:12];
					end
				end
				StRun: begin
					// skip the first cycle after start before checking the lanes
					if (!go_s1 && &done) begin
						if (last_q) begin
							state_q <= StPick;
							idx_q <= ClassBits'(1);
							best_q <= '0;
							best_val_q <= score[0];
						end else begin
							state_q <= StIdle;
						end
					end
				end
				StPick: begin
					if ({1'b0, idx_q} >= nc || idx_q == '0) begin
						state_q <= StOut;
					end else begin
						if (score[idx_q] > best_val_q) begin
							best_val_q <= score[idx_q];
							best_q <= idx_q;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				StOut: begin
					if (m_tready) state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	assign m_tvalid = (state_q == StOut);
	assign m_tdata = {1'b0, best_val_q, best_q};

	`include "bernoulli_naive_bayes_scorer_unit_assert.svh"
	`BNB_ASSERT_IMP(a_hold, m_tvalid && !m_tready, s_tready == 1'b0)
	`BNB_ASSERT_NXT(a_run, accept && !is_load, state_q == StRun)
	`BNB_ASSERT_IMP(a_best, m_tvalid, {1'b0, best_q} < nc)
endmodule

// ===== sim/bernoulli_naive_bayes_scorer_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bernoulli_naive_bayes_scorer_unit_tb
// Self-checking bench for the naive Bayes scorer. Loads class tables under
// several class and entry counts, streams samples through a random-idle
// driver, predicts each winning class and score, and checks them in order.
// ----------------------------------------------------------------------------
module bernoulli_naive_bayes_scorer_unit_tb;
	import bnb_pkg::*;

	localparam longint ScoreFloor = -(64'sd1 <<< 36);
	localparam logic signed [LogBits-1:0] LogMin = -(27'sd1 <<< 26);

	typedef struct {
		logic [0:0]                op;
		logic [ClassBits-1:0]      cls;
		logic [SlotBits-1:0]       slot;
		logic [FeatureBits-1:0]    fid;
		logic signed [LogBits-1:0] lp;
		logic signed [LogBits-1:0] la;
		logic                      last;
	} feat_item_t;

	typedef struct {
		logic [ClassBits-1:0]        cls;
		logic signed [ScoreBits-1:0] score;
	} verdict_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TdataBits-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OutBits-1:0]   m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [0:0]           cfg_index = RegClassCount;
	logic [10:0]          cfg_data = '0;

	bernoulli_naive_bayes_scorer_unit u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	feat_item_t item_q[$];
	verdict_t   verdict_q[$];

	// predictor state
	logic [FeatureBits-1:0]    tbl_fid[MaxClasses][MaxEntries];
	logic signed [LogBits-1:0] tbl_lp[MaxClasses][MaxEntries];
	logic signed [LogBits-1:0] tbl_la[MaxClasses][MaxEntries];
	longint                    acc[MaxClasses];
	int                        walk_pos[MaxClasses];
	int                        reg_classes = 2;
	int                        reg_entries = 1024;
	// generator's view of the table, updated at enqueue time
	logic [FeatureBits-1:0]    gen_fid[MaxClasses][MaxEntries];

	int send_pct = 26, recv_pct = 83;
	bit hold_armed = 0, hold_done = 0;
	int hold_cnt = 0;
	int errors = 0, results = 0, samples = 0, accepted = 0;

	function automatic logic signed [LogBits-1:0] sat_log(logic signed [LogBits-1:0] v);
		return (v > 0) ? '0 : v;
	endfunction

	function automatic void add_acc(int c, logic signed [LogBits-1:0] d);
		longint s;
		s = acc[c] + longint'(d);
		acc[c] = (s < ScoreFloor) ? ScoreFloor : s;
	endfunction

	function automatic void score_item(feat_item_t it);
		int nc, ne, p, best;
		bit stop;
		verdict_t v;
		if (it.op == OpLoad) begin
			tbl_fid[it.cls][it.slot] = it.fid;
			tbl_lp[it.cls][it.slot] = sat_log(it.lp);
			tbl_la[it.cls][it.slot] = sat_log(it.la);
			return;
		end
		nc = (reg_classes == 0) ? 1 : (reg_classes > MaxClasses) ? MaxClasses : reg_classes;
		ne = (reg_entries > MaxEntries) ? MaxEntries : reg_entries;
		for (int c = 0; c < nc; c++) begin
			p = walk_pos[c];
			stop = 0;
			while (!stop && p < ne) begin
				if (tbl_fid[c][p] < it.fid) begin
					add_acc(c, tbl_la[c][p]);
					p++;
				end else begin
					if (tbl_fid[c][p] == it.fid) begin
						add_acc(c, tbl_lp[c][p]);
						p++;
					end
					stop = 1;
				end
			end
			walk_pos[c] = p;
		end
		if (!it.last) return;
		best = 0;
		for (int c = 1; c < nc; c++)
			if (acc[c] > acc[best]) best = c;
		v.cls = best[ClassBits-1:0];
		v.score = acc[best][ScoreBits-1:0];
		verdict_q = {verdict_q, v};
		for (int c = 0; c < MaxClasses; c++) begin
			acc[c] = 0;
			walk_pos[c] = 0;
		end
	endfunction

	// driver: advance to the next queued item once the current one transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				score_item('{s_tuser, s_tdata[1:0], s_tdata[11:2], s_tdata[31:12],
					s_tdata[58:32], s_tdata[85:59], s_tlast});
				accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (item_q.size() != 0 && $urandom_range(99) >= send_pct) begin
					feat_item_t it;
					it = item_q.pop_front();
					s_tdata <= {2'b00, it.la, it.lp, it.fid, it.slot, it.cls};
					s_tuser <= it.op;
					s_tlast <= it.last;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver backpressure, with one long hold-off to fill the block
	always @(posedge clk) begin
		if (hold_armed && !hold_done) begin
			hold_done <= 1;
			hold_cnt <= 400;
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results++;
			if (verdict_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", m_tdata);
			end else begin
				verdict_t v;
				v = verdict_q.pop_front();
				if (m_tdata[1:0] !== v.cls || m_tdata[38:2] !== v.score) begin
					errors++;
					if (errors <= 10)
						$display("result %0d: expected class %0d score %0d, got class %0d score %0d",
							results, v.cls, v.score, m_tdata[1:0], $signed(m_tdata[38:2]));
				end
			end
		end
	end

	task automatic enq(logic [0:0] op, int cls, int slot, logic [FeatureBits-1:0] fid,
			logic signed [LogBits-1:0] lp, logic signed [LogBits-1:0] la, bit last);
		feat_item_t it;
		it = '{op, cls[ClassBits-1:0], slot[SlotBits-1:0], fid, lp, la, last};
		if (op == OpLoad) gen_fid[cls][slot] = fid;
		else if (last) samples++;
		item_q = {item_q, it};
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (item_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
		// a non-last sample can still be walking up to a full class list
		repeat (1100) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, int val);
		cfg_index <= idx;
		cfg_data <= val[10:0];
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == RegClassCount) reg_classes = val & 7;
		else reg_entries = val & 16'h7FF;
	endtask

	function automatic logic signed [LogBits-1:0] rand_log(bit floor_only);
		int r;
		r = $urandom_range(99);
		if (floor_only || r < 10) return LogMin;
		if (r < 20) return '0;
		if (r < 30) return LogBits'($urandom());	// either sign; positive saturates
		return -$signed({1'b0, 26'($urandom_range(0, 2000000))});
	endfunction

	// fill every used slot with ascending ids, then stream samples
	task automatic run_phase(int cc, int en, int n_samples, bit floor_only);
		int nc, ne, k, c;
		logic [FeatureBits-1:0] id;
		logic [FeatureBits-1:0] ids[$];
		write_reg(RegClassCount, cc);
		write_reg(RegEntries, en);
		nc = (cc == 0) ? 1 : (cc > MaxClasses) ? MaxClasses : cc;
		ne = (en > MaxEntries) ? MaxEntries : en;
		for (c = 0; c < nc; c++) begin
			id = FeatureBits'($urandom_range(0, 50));
			for (int s = 0; s < ne; s++) begin
				enq(OpLoad, c, s, id, rand_log(floor_only), rand_log(floor_only),
					$urandom_range(1));
				id = id + FeatureBits'($urandom_range(1, (ne > 512) ? 900 : 60000));
			end
		end
		repeat (n_samples) begin
			ids.delete();
			k = $urandom_range(1, 6);
			repeat (k) begin
				c = $urandom_range(nc - 1);
				if (ne == 0) id = FeatureBits'($urandom());
				else begin
					id = gen_fid[c][$urandom_range(ne - 1)];
					case ($urandom_range(5))
						0: id = id + 1'b1;
						1: id = id - 1'b1;
						2: id = FeatureBits'($urandom());
						default: ;
					endcase
				end
				ids = {ids, id};
			end
			if ($urandom_range(9) != 0) ids.sort();	// rest stay unordered
			for (int i = 0; i < ids.size(); i++) begin
				if (ne != 0 && $urandom_range(19) == 0)
					enq(OpLoad, $urandom_range(nc - 1), $urandom_range(ne - 1),
						FeatureBits'($urandom()), rand_log(floor_only),
						rand_log(floor_only), 1'b0);
				enq(OpSample, 0, 0, ids[i], '0, '0, i == ids.size() - 1);
			end
		end
		wait_idle();
	endtask

	initial begin
		for (int c = 0; c < MaxClasses; c++) begin
			acc[c] = 0;
			walk_pos[c] = 0;
			for (int s = 0; s < MaxEntries; s++) begin
				tbl_fid[c][s] = '0;
				tbl_lp[c][s] = '0;
				tbl_la[c][s] = '0;
				gen_fid[c][s] = '0;
			end
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: id extremes, saturation, misordered and repeated ids
		write_reg(RegClassCount, 4);
		write_reg(RegEntries, 2);
		enq(OpLoad, 0, 0, '0, LogMin, '0, 1'b0);
		enq(OpLoad, 0, 1, 20'hFFFFF, '0, LogMin, 1'b1);
		enq(OpLoad, 1, 0, 5, 27'sd100, 27'sh3FFFFFF, 1'b0);
		enq(OpLoad, 1, 1, 6, -27'sd70000, -27'sd3, 1'b0);
		enq(OpLoad, 2, 0, 3, -27'sd1, -27'sd1, 1'b0);
		enq(OpLoad, 2, 1, 20'h80000, LogMin, LogMin, 1'b1);
		enq(OpLoad, 3, 0, 5, -27'sd9, -27'sd5, 1'b0);
		enq(OpLoad, 3, 1, 6, -27'sd9, -27'sd5, 1'b0);
		enq(OpSample, 0, 0, '0, '0, '0, 1'b1);
		enq(OpSample, 0, 0, 20'hFFFFF, '0, '0, 1'b1);
		enq(OpSample, 0, 0, 5, '0, '0, 1'b0);
		enq(OpSample, 0, 0, 6, '0, '0, 1'b1);
		enq(OpSample, 0, 0, 6, '0, '0, 1'b0);
		enq(OpSample, 0, 0, 5, '0, '0, 1'b1);
		enq(OpSample, 0, 0, 3, '0, '0, 1'b0);
		enq(OpSample, 0, 0, 3, '0, '0, 1'b0);
		enq(OpLoad, 1, 1, 4, -27'sd11, -27'sd12, 1'b1);
		enq(OpSample, 0, 0, 4, '0, '0, 1'b1);
		wait_idle();

		run_phase(2, 8, 12, 0);
		run_phase(1, 16, 10, 0);
		run_phase(4, 1, 12, 0);
		send_pct = 83;
		recv_pct = 26;
		hold_armed = 1;
		run_phase(7, 6, 12, 0);
		run_phase(3, 0, 8, 0);
		run_phase(0, 5, 10, 0);
		send_pct = 0;
		recv_pct = 0;
		run_phase(4, 12, 12, 0);
		// full single-class list at the log floor drives the score to its limit
		run_phase(1, 2047, 6, 1);
		run_phase(2, 3, 12, 0);

		$display("%0d items transferred, %0d samples scored, %0d results checked",
			accepted, samples, results);
		$display("class counts 0..7, entry counts 0..2047, floor-level scores covered");
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else begin
			$display("%0d mismatches", errors);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("timeout");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
